// File: rtl/viu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package viu_pkg;

	typedef logic [1:0] op_t;
	typedef logic [6:0] offset_t;

	localparam op_t OP_READ   = 2'd0;
	localparam op_t OP_WRITE  = 2'd1;
	localparam op_t OP_UPDATE = 2'd2;
	localparam op_t OP_FETCH  = 2'd3;

	localparam offset_t OFF_PENDING   = 7'h00;
	localparam offset_t OFF_ACK       = 7'h02;
	localparam offset_t OFF_TRIGGER   = 7'h04;
	localparam offset_t OFF_ENABLE0   = 7'h06;
	localparam offset_t OFF_ENABLE1   = 7'h08;
	localparam offset_t OFF_ENABLE2   = 7'h0A;
	localparam offset_t OFF_ENABLE3   = 7'h0C;
	localparam offset_t OFF_MODE      = 7'h0E;
	localparam offset_t OFF_INVERT    = 7'h10;
	localparam offset_t OFF_VEC_FIRST = 7'h12;
	localparam offset_t OFF_VEC_LAST  = 7'h50;
	localparam offset_t OFF_DISABLE   = 7'h52;

	localparam logic [15:0] VEC_HI_KEEP = 16'h8003;

	localparam int MAX_LINES = 4;

	// Only bits 31, 17 and 16 of a vector are kept in its high half.
	function automatic logic [2:0] vec_hi_pack(input logic [15:0] wd);
		logic [15:0] kept;
		kept = wd & VEC_HI_KEEP;
		return {kept[15], kept[1:0]};
	endfunction

	function automatic logic [15:0] vec_hi_word(input logic [2:0] hi);
		return {hi[2], 13'd0, hi[1:0]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/vectored_interrupt_unit.sv
// Vectored interrupt unit with NUM_SOURCES sources and NUM_LINES output lines.
// Each accepted word passes through the input register and then the result register before it is shown.
// Throughput: one word per cycle; the input register and the result register
// each hold one word, and in_stall rises only while a shown result is stalled.
// Reset clears all masks, pending and level state, the vector table and valids.
`timescale 1ns / 1ps
`default_nettype none

module vectored_interrupt_unit #(
	parameter int NUM_SOURCES = 16,
	parameter int NUM_LINES   = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     operation,
	input  wire logic [6:0]                     reg_offset,
	input  wire logic [15:0]                    write_data,
	input  wire logic [15:0]                    source_lines,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [31:0]                         read_data,
	output logic [viu_pkg::MAX_LINES-1:0]       irq_lines
);

	localparam int SRC_IW  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int LINE_IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	logic                   valid_s1;
	viu_pkg::op_t           op_s1;
	viu_pkg::offset_t       off_s1;
	logic [15:0]            wd_s1;
	logic [15:0]            src_s1;

	logic [NUM_SOURCES-1:0] pend_q, level_q, hold_q, trig_q, mode_q, inv_q, dis_q;
	logic [NUM_SOURCES-1:0] en_q [NUM_LINES];
	logic [2:0]             vhi_q [NUM_SOURCES];
	logic [15:0]            vlo_q [NUM_SOURCES];

	logic                   out_valid_q;
	logic [31:0]            rd_q;
	logic [viu_pkg::MAX_LINES-1:0] lines_q;

	logic                   advance, fire;
	logic [NUM_SOURCES-1:0] wm, lvl, pend_r, pend_d;
	logic [NUM_SOURCES-1:0] hold_d, trig_d, mode_d, inv_d, dis_d;
	logic [NUM_SOURCES-1:0] en_d [NUM_LINES];
	logic                   ack;
	logic                   vwr_hi, vwr_lo;
	viu_pkg::offset_t       diff_e, diff_v;
	logic [1:0]             eidx;
	logic [3:0]             vidx;
	logic                   en_ok, v_ok;
	logic [31:0]            rd_d;
	logic [viu_pkg::MAX_LINES-1:0] lines_d;
	logic [NUM_SOURCES-1:0] hit;
	logic [SRC_IW-1:0]      fidx;
	logic                   found;

	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign read_data = rd_q;
	assign irq_lines = lines_q;

	assign diff_e = off_s1 - viu_pkg::OFF_ENABLE0;
	assign diff_v = off_s1 - viu_pkg::OFF_VEC_FIRST;
	assign eidx   = diff_e[2:1];
	assign vidx   = diff_v[5:2];
	assign en_ok  = 32'(eidx) < NUM_LINES;
	assign v_ok   = 32'(vidx) < NUM_SOURCES;
	assign wm     = wd_s1[NUM_SOURCES-1:0];

	always_comb begin
		hit   = pend_q & en_q[NUM_LINES-1];
		fidx  = '0;
		found = 1'b0;
		for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				fidx  = SRC_IW'(i);
				found = 1'b1;
			end
		end
	end

	always_comb begin
		hold_d = hold_q;
		trig_d = trig_q;
		mode_d = mode_q;
		inv_d  = inv_q;
		dis_d  = dis_q;
		en_d   = en_q;
		ack    = 1'b0;
		vwr_hi = 1'b0;
		vwr_lo = 1'b0;
		rd_d   = '0;
		unique case (op_s1)
			viu_pkg::OP_READ: begin
				if (!off_s1[0]) begin
					unique case (off_s1) inside
						viu_pkg::OFF_PENDING: rd_d = 32'(pend_q);
						viu_pkg::OFF_TRIGGER: rd_d = 32'(trig_q);
						viu_pkg::OFF_ENABLE0, viu_pkg::OFF_ENABLE1,
						viu_pkg::OFF_ENABLE2, viu_pkg::OFF_ENABLE3: begin
							if (en_ok) rd_d = 32'(en_q[eidx[LINE_IW-1:0]]);
						end
						viu_pkg::OFF_MODE:    rd_d = 32'(mode_q);
						viu_pkg::OFF_INVERT:  rd_d = 32'(inv_q);
						[viu_pkg::OFF_VEC_FIRST:viu_pkg::OFF_VEC_LAST]: begin
							if (v_ok) begin
								if (diff_v[1]) rd_d = 32'(vlo_q[vidx[SRC_IW-1:0]]);
								else rd_d = 32'(viu_pkg::vec_hi_word(vhi_q[vidx[SRC_IW-1:0]]));
							end
						end
						viu_pkg::OFF_DISABLE: rd_d = 32'(dis_q);
						default:              rd_d = '0;
					endcase
				end
			end
			viu_pkg::OP_WRITE: begin
				if (!off_s1[0]) begin
					unique case (off_s1) inside
						viu_pkg::OFF_ACK:     ack    = 1'b1;
						viu_pkg::OFF_TRIGGER: trig_d = wm;
						viu_pkg::OFF_ENABLE0, viu_pkg::OFF_ENABLE1,
						viu_pkg::OFF_ENABLE2, viu_pkg::OFF_ENABLE3: begin
							if (en_ok) en_d[eidx[LINE_IW-1:0]] = wm;
						end
						viu_pkg::OFF_MODE:    mode_d = wm;
						viu_pkg::OFF_INVERT:  inv_d  = wm;
						[viu_pkg::OFF_VEC_FIRST:viu_pkg::OFF_VEC_LAST]: begin
							vwr_lo = v_ok && diff_v[1];
							vwr_hi = v_ok && !diff_v[1];
						end
						viu_pkg::OFF_DISABLE: dis_d  = wm;
						default:              ack    = 1'b0;
					endcase
				end
			end
			viu_pkg::OP_UPDATE: hold_d = src_s1[NUM_SOURCES-1:0];
			viu_pkg::OP_FETCH: begin
				if (found) begin
					rd_d = {viu_pkg::vec_hi_word(vhi_q[fidx]), vlo_q[fidx]};
				end
			end
			default: rd_d = '0;
		endcase

		lvl    = ((hold_d ^ inv_d) | trig_d) & ~dis_d;
		pend_r = pend_q | (lvl & ~level_q);
		pend_d = ack ? (pend_r & ~(wm & (mode_q | ~lvl))) : pend_r;

		lines_d = '0;
		for (int l = 0; l < NUM_LINES; l++) begin
			lines_d[l] = |(en_d[l] & pend_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= operation;
			off_s1 <= reg_offset;
			wd_s1  <= write_data;
			src_s1 <= source_lines;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			level_q <= '0;
			hold_q  <= '0;
			trig_q  <= '0;
			mode_q  <= '0;
			inv_q   <= '0;
			dis_q   <= '0;
			for (int l = 0; l < NUM_LINES; l++) en_q[l] <= '0;
			for (int v = 0; v < NUM_SOURCES; v++) begin
				vhi_q[v] <= '0;
				vlo_q[v] <= '0;
			end
		end else if (fire) begin
			pend_q  <= pend_d;
			level_q <= lvl;
			hold_q  <= hold_d;
			trig_q  <= trig_d;
			mode_q  <= mode_d;
			inv_q   <= inv_d;
			dis_q   <= dis_d;
			for (int l = 0; l < NUM_LINES; l++) en_q[l] <= en_d[l];
			if (vwr_hi) vhi_q[vidx[SRC_IW-1:0]] <= viu_pkg::vec_hi_pack(wd_s1);
			if (vwr_lo) vlo_q[vidx[SRC_IW-1:0]] <= wd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rd_q    <= rd_d;
			lines_q <= lines_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/viu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module viu_checker #(
	parameter int NUM_LINES = 4
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] read_data,
	input wire logic [3:0]  irq_lines
);

	// The input side only waits while a shown result word is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(irq_lines)))
		else $error("stalled result word changed");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result word shown during reset");

	a_unused_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((irq_lines >> NUM_LINES) == 4'd0))
		else $error("interrupt line beyond the configured count is set");

endmodule

bind vectored_interrupt_unit viu_checker #(.NUM_LINES(NUM_LINES)) u_viu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.read_data (read_data),
	.irq_lines (irq_lines)
);

`default_nettype wire
